FILE: hw/rtl/ss3d_pkg.sv
// Shared types and constants for the 3D serpentine scan generator.
// Used by ss3d_out_buf and serpentine_scan_3d_generator; depends on nothing.
package ss3d_pkg;

    localparam int COORD_W = 13;
    localparam int CFG_W   = 13;
    localparam int DEPTH_W = 4;
    localparam int INDEX_W = 2;

    localparam logic [INDEX_W-1:0] REG_NUM_ROWS   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_NUM_COLS   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_DEPTH_LOG2 = 2'd2;

    localparam int ROWS_RESET  = 8;
    localparam int COLS_RESET  = 8;
    localparam int DEPTH_RESET = 3;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] plane;
        logic               last;
    } t_coord;

endpackage

FILE: hw/rtl/serpentine_scan_3d_generator.sv
// 3D serpentine scan generator: one (row, col, plane, last) item per input item.
// An accepted item is registered in the output register, or held in the skid entry while the output stalls.
// Throughput: one item per cycle while o_stall is low; a two-entry output buffer
// (output register plus skid) absorbs stalls.
// Reset: sizes return to 8 rows, 8 cols, 2^3 planes, the scan returns to its
// first coordinate with both directions forward, and the output buffer empties.
module serpentine_scan_3d_generator #(
    parameter int MAX_ROWS       = 4096,
    parameter int MAX_COLS       = 4096,
    parameter int MAX_DEPTH_LOG2 = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ss3d_pkg::INDEX_W-1:0]     i_cfg_index,
    input  logic [ss3d_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_restart,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ss3d_pkg::COORD_W-1:0]     o_row,
    output logic [ss3d_pkg::COORD_W-1:0]     o_col,
    output logic [ss3d_pkg::COORD_W-1:0]     o_plane,
    output logic                             o_last
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW = (MAX_DEPTH_LOG2 > 0) ? MAX_DEPTH_LOG2 : 1;

    // last index for a size register: zero acts as one, oversize clamps
    function automatic logic [31:0] size_last(input logic [ss3d_pkg::CFG_W-1:0] v,
                                              input int maxv);
        logic [31:0] res;
        if (v == '0) begin
            res = 32'd0;
        end else if (32'(v) > 32'(maxv)) begin
            res = 32'(maxv) - 32'd1;
        end else begin
            res = 32'(v) - 32'd1;
        end
        return res;
    endfunction

    // plane count minus one: a mask of the clamped depth's low bits
    function automatic logic [PW-1:0] plane_last(input logic [ss3d_pkg::DEPTH_W-1:0] d);
        logic [PW-1:0] m;
        int            dd;
        dd = (int'(d) > MAX_DEPTH_LOG2) ? MAX_DEPTH_LOG2 : int'(d);
        for (int i = 0; i < PW; i++) begin
            m[i] = (i < dd);
        end
        return m;
    endfunction

    logic [RW-1:0] r_nr_last;
    logic [CW-1:0] r_nc_last;
    logic [PW-1:0] r_np_last;

    logic [CW-1:0] r_col_step, n_col_step;
    logic [RW-1:0] r_row_step, n_row_step;
    logic [PW-1:0] r_plane,    n_plane;
    logic          r_col_rev,  n_col_rev;
    logic          r_row_rev,  n_row_rev;

    logic [CW-1:0] w_cs;
    logic [RW-1:0] w_rs;
    logic [PW-1:0] w_ps;
    logic          w_cr;
    logic          w_rr;
    logic          w_col_end;
    logic          w_row_end;
    logic          w_fin;
    logic [31:0]   w_row_val;
    logic [31:0]   w_col_val;
    logic [31:0]   w_plane_val;
    logic          w_accept;
    logic          w_cfg_hit;
    logic          w_full;

    ss3d_pkg::t_coord w_item;
    ss3d_pkg::t_coord w_out;

    assign w_accept  = i_valid && !w_full;
    assign o_stall   = w_full;
    assign w_cfg_hit = i_cfg_we && (i_cfg_index == ss3d_pkg::REG_NUM_ROWS ||
                                    i_cfg_index == ss3d_pkg::REG_NUM_COLS ||
                                    i_cfg_index == ss3d_pkg::REG_DEPTH_LOG2);

    // restart takes effect before this item's coordinate is formed
    always_comb begin
        w_cs = i_restart ? '0   : r_col_step;
        w_rs = i_restart ? '0   : r_row_step;
        w_ps = i_restart ? '0   : r_plane;
        w_cr = i_restart ? 1'b0 : r_col_rev;
        w_rr = i_restart ? 1'b0 : r_row_rev;

        w_col_end = (w_cs == r_nc_last);
        w_row_end = (w_rs == r_nr_last);
        w_fin     = w_col_end && w_row_end && (w_ps == r_np_last);

        w_row_val   = w_rr ? (32'(r_nr_last) - 32'(w_rs) + 32'd1) : (32'(w_rs) + 32'd1);
        w_col_val   = w_cr ? (32'(r_nc_last) - 32'(w_cs) + 32'd1) : (32'(w_cs) + 32'd1);
        w_plane_val = 32'(w_ps) + 32'd1;

        w_item.row   = w_row_val[ss3d_pkg::COORD_W-1:0];
        w_item.col   = w_col_val[ss3d_pkg::COORD_W-1:0];
        w_item.plane = w_plane_val[ss3d_pkg::COORD_W-1:0];
        w_item.last  = w_fin;

        n_col_step = w_cs + CW'(1);
        n_row_step = w_rs;
        n_plane    = w_ps;
        n_col_rev  = w_cr;
        n_row_rev  = w_rr;
        if (w_fin) begin
            n_col_step = '0;
            n_row_step = '0;
            n_plane    = '0;
            n_col_rev  = 1'b0;
            n_row_rev  = 1'b0;
        end else if (w_col_end) begin
            n_col_step = '0;
            n_col_rev  = !w_cr;
            n_row_step = w_rs + RW'(1);
            if (w_row_end) begin
                n_row_step = '0;
                n_row_rev  = !w_rr;
                n_plane    = w_ps + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nr_last  <= RW'(size_last(ss3d_pkg::CFG_W'(ss3d_pkg::ROWS_RESET), MAX_ROWS));
            r_nc_last  <= CW'(size_last(ss3d_pkg::CFG_W'(ss3d_pkg::COLS_RESET), MAX_COLS));
            r_np_last  <= plane_last(ss3d_pkg::DEPTH_W'(ss3d_pkg::DEPTH_RESET));
            r_col_step <= '0;
            r_row_step <= '0;
            r_plane    <= '0;
            r_col_rev  <= 1'b0;
            r_row_rev  <= 1'b0;
        end else if (w_cfg_hit) begin
            case (i_cfg_index)
                ss3d_pkg::REG_NUM_ROWS: begin
                    r_nr_last <= RW'(size_last(i_cfg_data, MAX_ROWS));
                end
                ss3d_pkg::REG_NUM_COLS: begin
                    r_nc_last <= CW'(size_last(i_cfg_data, MAX_COLS));
                end
                ss3d_pkg::REG_DEPTH_LOG2: begin
                    r_np_last <= plane_last(i_cfg_data[ss3d_pkg::DEPTH_W-1:0]);
                end
                default: begin
                end
            endcase
            // a write to any of the three size registers sends the scan home
            r_col_step <= '0;
            r_row_step <= '0;
            r_plane    <= '0;
            r_col_rev  <= 1'b0;
            r_row_rev  <= 1'b0;
        end else if (w_accept) begin
            r_col_step <= n_col_step;
            r_row_step <= n_row_step;
            r_plane    <= n_plane;
            r_col_rev  <= n_col_rev;
            r_row_rev  <= n_row_rev;
        end
    end

    ss3d_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_data  (w_item),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_row   = w_out.row;
    assign o_col   = w_out.col;
    assign o_plane = w_out.plane;
    assign o_last  = w_out.last;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid entry held while output register empty");

    a_steps_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_step <= r_nc_last) && (r_row_step <= r_nr_last) && (r_plane <= r_np_last))
        else $error("scan step beyond configured size");

    a_wrap_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_fin) |=> (r_col_step == '0 && r_row_step == '0 && r_plane == '0 &&
                                 !r_col_rev && !r_row_rev))
        else $error("scan did not wrap to start after final coordinate");

    a_cfg_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> (r_col_step == '0 && r_row_step == '0 && r_plane == '0))
        else $error("register write did not restart the scan");

endmodule

FILE: hw/rtl/ss3d_out_buf.sv
// Output register with a skid stage for scan coordinate items.
// Depends on ss3d_pkg for the t_coord item type.
module ss3d_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ss3d_pkg::t_coord i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_stall,
    output ss3d_pkg::t_coord o_data
);

    logic            r_out_valid;
    logic            r_skid_valid;
    ss3d_pkg::t_coord r_out;
    ss3d_pkg::t_coord r_skid;
    logic            w_move;

    assign w_move = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid  <= r_skid_valid || i_load;
            r_skid_valid <= 1'b0;
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    // drain the skid entry first so item order holds
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_load) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: tb/serpentine_scan_3d_generator_tb.sv
`timescale 1ns / 100ps
// Testbench for serpentine_scan_3d_generator: directed and random scan sizes,
// restarts and register writes, with each coordinate predicted and checked.
// Depends on ss3d_pkg and the generator RTL.
module serpentine_scan_3d_generator_tb;

    localparam int MAX_ROWS       = 4096;
    localparam int MAX_COLS       = 4096;
    localparam int MAX_DEPTH_LOG2 = 12;

    localparam logic [ss3d_pkg::INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam int STALL_PCT    = 9;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1070;
    localparam int ROW_COLS     = 256;

    // Tracks the scan position and holds the coordinates still owed by the block.
    class scan_scoreboard;
        logic [ss3d_pkg::CFG_W-1:0]   rows_reg;
        logic [ss3d_pkg::CFG_W-1:0]   cols_reg;
        logic [ss3d_pkg::DEPTH_W-1:0] depth_reg;
        bit [11:0]                    col_step;
        bit [11:0]                    row_step;
        bit [11:0]                    plane_idx;
        bit                           col_rev;
        bit                           row_rev;
        ss3d_pkg::t_coord             coords_due[$];
        int                           mismatches;

        function new();
            rows_reg   = ss3d_pkg::CFG_W'(ss3d_pkg::ROWS_RESET);
            cols_reg   = ss3d_pkg::CFG_W'(ss3d_pkg::COLS_RESET);
            depth_reg  = ss3d_pkg::DEPTH_W'(ss3d_pkg::DEPTH_RESET);
            mismatches = 0;
            home();
        endfunction

        function void home();
            col_step  = '0;
            row_step  = '0;
            plane_idx = '0;
            col_rev   = 1'b0;
            row_rev   = 1'b0;
        endfunction

        // Zero acts as one; anything above the maximum acts as the maximum.
        function int clamp_size(logic [ss3d_pkg::CFG_W-1:0] v, int maxv);
            if (v == '0)
                return 1;
            if (int'(v) > maxv)
                return maxv;
            return int'(v);
        endfunction

        function int plane_count();
            return 1 << ((int'(depth_reg) > MAX_DEPTH_LOG2) ? MAX_DEPTH_LOG2 : int'(depth_reg));
        endfunction

        function longint volume();
            return longint'(clamp_size(rows_reg, MAX_ROWS)) *
                   longint'(clamp_size(cols_reg, MAX_COLS)) * longint'(plane_count());
        endfunction

        function void write_reg(logic [ss3d_pkg::INDEX_W-1:0] idx,
                                logic [ss3d_pkg::CFG_W-1:0] data);
            case (idx)
                ss3d_pkg::REG_NUM_ROWS:   rows_reg = data;
                ss3d_pkg::REG_NUM_COLS:   cols_reg = data;
                ss3d_pkg::REG_DEPTH_LOG2: depth_reg = data[ss3d_pkg::DEPTH_W-1:0];
                default:                  return;
            endcase
            home();
        endfunction

        function void note_item(bit restart);
            int               nr;
            int               nc;
            int               np;
            bit               fin;
            ss3d_pkg::t_coord c;
            nr = clamp_size(rows_reg, MAX_ROWS);
            nc = clamp_size(cols_reg, MAX_COLS);
            np = plane_count();
            if (restart)
                home();
            c.row   = ss3d_pkg::COORD_W'(row_rev ? nr - int'(row_step) : int'(row_step) + 1);
            c.col   = ss3d_pkg::COORD_W'(col_rev ? nc - int'(col_step) : int'(col_step) + 1);
            c.plane = ss3d_pkg::COORD_W'(int'(plane_idx) + 1);
            fin = (int'(col_step) + 1 == nc) && (int'(row_step) + 1 == nr) &&
                  (int'(plane_idx) + 1 == np);
            c.last = fin;
            coords_due.push_back(c);
            if (fin) begin
                home();
                return;
            end
            // Advance; the column direction carries over plane boundaries.
            if (int'(col_step) + 1 < nc) begin
                col_step++;
            end else begin
                col_step = '0;
                col_rev  = ~col_rev;
                if (int'(row_step) + 1 < nr) begin
                    row_step++;
                end else begin
                    row_step = '0;
                    row_rev  = ~row_rev;
                    plane_idx++;
                end
            end
        endfunction

        task report(string what, int got, int want);
            $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [ss3d_pkg::COORD_W-1:0] row, logic [ss3d_pkg::COORD_W-1:0] col,
                          logic [ss3d_pkg::COORD_W-1:0] plane, logic last);
            ss3d_pkg::t_coord want;
            if (coords_due.size() == 0) begin
                report("unrequested item, row", int'(row), 0);
                return;
            end
            want = coords_due.pop_front();
            if (row !== want.row)
                report("row", int'(row), int'(want.row));
            if (col !== want.col)
                report("col", int'(col), int'(want.col));
            if (plane !== want.plane)
                report("plane", int'(plane), int'(want.plane));
            if (last !== want.last)
                report("last", int'(last), int'(want.last));
        endtask

        function int pending();
            return coords_due.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [ss3d_pkg::INDEX_W-1:0] i_cfg_index;
    logic [ss3d_pkg::CFG_W-1:0]   i_cfg_data;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_restart;
    logic                         o_valid;
    logic                         i_stall;
    logic [ss3d_pkg::COORD_W-1:0] o_row;
    logic [ss3d_pkg::COORD_W-1:0] o_col;
    logic [ss3d_pkg::COORD_W-1:0] o_plane;
    logic                         o_last;

    scan_scoreboard sb;
    bit             no_idle = 1'b0;
    int             idle_cycles = 0;

    serpentine_scan_3d_generator #(
        .MAX_ROWS       (MAX_ROWS),
        .MAX_COLS       (MAX_COLS),
        .MAX_DEPTH_LOG2 (MAX_DEPTH_LOG2)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_plane     (o_plane),
        .o_last      (o_last)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Check each accepted coordinate, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_row, o_col, o_plane, o_last);
        i_stall <= !no_idle && ($urandom_range(99) < STALL_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(bit restart);
        while (!no_idle && $urandom_range(99) < STALL_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_item(restart);
    endtask

    // Drop valid and wait until every owed coordinate has come out.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [ss3d_pkg::INDEX_W-1:0] idx,
                             logic [ss3d_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [ss3d_pkg::CFG_W-1:0] pick_size();
        case ($urandom_range(5))
            0:       return '0;
            1:       return ss3d_pkg::CFG_W'(1);
            2:       return ss3d_pkg::CFG_W'(MAX_ROWS);
            3:       return '1;
            4:       return ss3d_pkg::CFG_W'($urandom_range(MAX_ROWS + 1, 8190));
            default: return ss3d_pkg::CFG_W'($urandom_range(2, MAX_ROWS - 1));
        endcase
    endfunction

    initial begin
        int                         random_items;
        int                         len;
        int                         pct;
        bit                         extreme;
        longint                     vol;
        logic [8:0]                 depth_junk;
        logic [ss3d_pkg::CFG_W-1:0] depth_data;

        random_items = 0;
        sb = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_restart   <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= ss3d_pkg::REG_NUM_ROWS;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset sizes: first steps of the volume, then a restart.
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();

        // Zero sizes act as one, so every item is the last of the volume.
        cfg_write(ss3d_pkg::REG_NUM_ROWS, '0);
        cfg_write(ss3d_pkg::REG_NUM_COLS, '0);
        cfg_write(ss3d_pkg::REG_DEPTH_LOG2, '0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();

        // Two planes of 2x3: direction flips across the plane edge, short of the wrap.
        // Upper data bits of the depth register are dropped.
        cfg_write(ss3d_pkg::REG_NUM_ROWS, ss3d_pkg::CFG_W'(2));
        cfg_write(ss3d_pkg::REG_NUM_COLS, ss3d_pkg::CFG_W'(3));
        cfg_write(ss3d_pkg::REG_DEPTH_LOG2, 13'h1FF1);
        repeat (10) send_item(1'b0);
        drain();

        // Unknown register: the scan must carry on where it stopped.
        cfg_write(REG_UNUSED, '1);
        repeat (3) send_item(1'b0);
        drain();

        // Oversize values clamp to the maximum.
        cfg_write(ss3d_pkg::REG_NUM_ROWS, '1);
        cfg_write(ss3d_pkg::REG_NUM_COLS, '1);
        cfg_write(ss3d_pkg::REG_DEPTH_LOG2, ss3d_pkg::CFG_W'(15));
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        drain();

        // One long row at full rate, then wrap to its start.
        no_idle = 1'b1;
        cfg_write(ss3d_pkg::REG_NUM_ROWS, ss3d_pkg::CFG_W'(1));
        cfg_write(ss3d_pkg::REG_NUM_COLS, ss3d_pkg::CFG_W'(ROW_COLS));
        cfg_write(ss3d_pkg::REG_DEPTH_LOG2, '0);
        repeat (ROW_COLS + 2) send_item(1'b0);
        drain();
        no_idle = 1'b0;

        // Mostly small volumes scanned through and past the wrap; some phases
        // keep the old sizes and resume mid-scan, some are restart-heavy.
        while (random_items < RANDOM_ITEMS) begin
            extreme = ($urandom_range(9) == 0);
            if ($urandom_range(2) != 0)
                cfg_write(ss3d_pkg::REG_NUM_ROWS,
                          extreme ? pick_size() : ss3d_pkg::CFG_W'($urandom_range(0, 4)));
            if ($urandom_range(2) != 0)
                cfg_write(ss3d_pkg::REG_NUM_COLS,
                          extreme ? pick_size() : ss3d_pkg::CFG_W'($urandom_range(0, 5)));
            if ($urandom_range(2) != 0) begin
                depth_junk = ($urandom_range(3) == 0) ? 9'($urandom) : '0;
                depth_data = {depth_junk, 4'($urandom_range(0, 2))};
                cfg_write(ss3d_pkg::REG_DEPTH_LOG2,
                          extreme ? ss3d_pkg::CFG_W'($urandom) : depth_data);
            end
            if ($urandom_range(7) == 0)
                cfg_write(REG_UNUSED, ss3d_pkg::CFG_W'($urandom));

            vol = sb.volume();
            len = (vol <= 100) ? $urandom_range(1, 2 * int'(vol) + 3) : $urandom_range(4, 40);
            pct = ($urandom_range(4) == 0) ? 30 : 3;
            repeat (len) begin
                no_idle = (random_items >= 500 && random_items < 750);
                send_item($urandom_range(99) < pct);
                random_items++;
            end
            drain();
            no_idle = 1'b0;
        end

        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
